FILE: sv/plbu_pkg.sv
// Shared types and constants for the price level book update block.
// No dependencies; every module of the block but plbu_ram imports this package.
package plbu_pkg;

  localparam int NUM_BOOKS_DEF = 16;
  localparam int DEPTH_DEF     = 16;

  localparam int BOOK_W   = 4;
  localparam int PRICE_W  = 16;
  localparam int QTY_W    = 16;
  localparam int LEVEL_W  = 4;
  localparam int CNT_O_W  = 5;
  localparam int IN_W     = 48;
  localparam int OUT_W    = 80;
  localparam int MAX_BOOK = 16;
  localparam int WORD_W   = PRICE_W + QTY_W;

  localparam logic OP_DELTA = 1'b0;

  typedef enum logic [1:0] {
    K_DELTA,
    K_READ,
    K_BAD
  } kind_e;

  typedef struct packed {
    kind_e                kind;
    logic [BOOK_W-1:0]    book;
    logic                 is_bid;
    logic [PRICE_W-1:0]   price;
    logic [QTY_W-1:0]     qty;
    logic [LEVEL_W-1:0]   level;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INS_WR,
    S_RES_RD,
    S_RES_CK
  } state_e;

  function automatic logic ranks_better(input logic bid, input logic [PRICE_W-1:0] a,
                                        input logic [PRICE_W-1:0] b);
    return bid ? (a > b) : (a < b);
  endfunction

endpackage

FILE: sv/price_level_book_update.sv
// A read passes S_RES_RD and S_RES_CK and then the output register; a delta first scans
// the levels ahead of the target (S_SCAN_RD, S_SCAN_CK per level), then shifts each moved
// level (S_SHIFT_RD, S_SHIFT_WR) before its result read. The back end takes one item at a
// time, none before the last is through; the registered RAM read sets the pace.
// A two-entry command queue and an output register decouple both stream sides.
// Reset clears the level counts at once; book RAM contents beyond a count are never reported.
module price_level_book_update #(
  parameter int NUM_BOOKS = plbu_pkg::NUM_BOOKS_DEF,
  parameter int DEPTH     = plbu_pkg::DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // book_id, is_bid, price, quantity, level, zero pad
  input  logic [plbu_pkg::IN_W-1:0]  s_axis_tdata_i,
  // operation
  input  logic                       s_axis_tuser_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // bid_price, bid_size, ask_price, ask_size, bid_levels, ask_levels, dropped, zero pad
  output logic [plbu_pkg::OUT_W-1:0] m_axis_tdata_o
);
  import plbu_pkg::*;

  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  plbu_front #(.NUM_BOOKS(NUM_BOOKS)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_pop_i       (cmd_pop)
  );

  plbu_back #(.NUM_BOOKS(NUM_BOOKS), .DEPTH(DEPTH)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (cmd),
    .cmd_pop_o       (cmd_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

`ifndef SYNTHESIS
  localparam logic [4:0] DEPTH_LV = 5'(DEPTH);

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[74]) |->
      (m_axis_tdata_o[68:64] == DEPTH_LV || m_axis_tdata_o[73:69] == DEPTH_LV))
    else $error("dropped without a full side");

  a_bid_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (DEPTH < 32 && m_axis_tvalid_o && m_axis_tdata_o[68:64] == 5'd0) |->
      (m_axis_tdata_o[31:0] == 32'd0))
    else $error("empty bid side reports a level");

  a_ask_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (DEPTH < 32 && m_axis_tvalid_o && m_axis_tdata_o[73:69] == 5'd0) |->
      (m_axis_tdata_o[63:32] == 32'd0))
    else $error("empty ask side reports a level");
`endif

endmodule

FILE: sv/plbu_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
module plbu_ram #(
  parameter int W = 32,
  parameter int D = 256
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/plbu_front.sv
// Front end: accepts stream transfers, classifies them and queues commands.
// Depends on plbu_pkg.
module plbu_front #(
  parameter int NUM_BOOKS = plbu_pkg::NUM_BOOKS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [plbu_pkg::IN_W-1:0]   s_axis_tdata_i,
  input  logic                        s_axis_tuser_i,
  output logic                        cmd_valid_o,
  output plbu_pkg::cmd_t              cmd_o,
  input  logic                        cmd_pop_i
);
  import plbu_pkg::*;

  cmd_t       fifo_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  cmd_t       cmd_in;
  logic       push;

  always_comb begin
    cmd_in.book   = s_axis_tdata_i[3:0];
    cmd_in.is_bid = s_axis_tdata_i[4];
    cmd_in.price  = s_axis_tdata_i[20:5];
    cmd_in.qty    = s_axis_tdata_i[36:21];
    cmd_in.level  = s_axis_tdata_i[40:37];
    if (int'(cmd_in.book) >= NUM_BOOKS) begin
      cmd_in.kind = K_BAD;
    end else if (s_axis_tuser_i != OP_DELTA) begin
      cmd_in.kind = K_READ;
    end else begin
      // price zero delta reports like a read of the best level
      cmd_in.kind  = (cmd_in.price == '0) ? K_READ : K_DELTA;
      cmd_in.level = '0;
    end
  end

  assign s_axis_tready_o = (cnt_q != 2'd2);
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign cmd_valid_o     = (cnt_q != 2'd0);
  assign cmd_o           = fifo_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wp_q <= !wp_q;
      end
      if (cmd_pop_i) begin
        rp_q <= !rp_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop_i);
    end
  end

endmodule

FILE: sv/plbu_back.sv
// Back end: sequencer that scans, shifts and reads the book RAMs, plus output register.
// Depends on plbu_pkg and plbu_ram.
module plbu_back #(
  parameter int NUM_BOOKS = plbu_pkg::NUM_BOOKS_DEF,
  parameter int DEPTH     = plbu_pkg::DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  input  plbu_pkg::cmd_t              cmd_i,
  output logic                        cmd_pop_o,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [plbu_pkg::OUT_W-1:0]  m_axis_tdata_o
);
  import plbu_pkg::*;

  localparam int NB  = (NUM_BOOKS < MAX_BOOK) ? NUM_BOOKS : MAX_BOOK;
  localparam int BIW = (NB > 1) ? $clog2(NB) : 1;
  localparam int NBS = 2 ** BIW;
  localparam int MD  = NB * DEPTH;
  localparam int AW  = $clog2(MD);
  localparam int LW  = $clog2(DEPTH + 1);

  state_e            state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [AW-1:0]     base_q, base_d;
  logic [LW-1:0]     n_q, n_d, pos_q, pos_d, k_q, k_d;
  logic              del_q, del_d, drop_q, drop_d;
  logic [LW-1:0]     bid_cnt_q [NBS];
  logic [LW-1:0]     ask_cnt_q [NBS];
  logic              cnt_we;
  logic [LW-1:0]     cnt_val;
  logic              out_valid_q;
  logic [OUT_W-1:0]  out_data_q;
  logic              out_load;
  logic [OUT_W-1:0]  out_data;

  logic              we;
  logic [LW-1:0]     widx, ridx;
  logic [WORD_W-1:0] wdata, bid_rdata, ask_rdata;
  logic [AW-1:0]     waddr, raddr;

  logic              dec_en, dec_match;
  logic [BIW-1:0]    bk, bk_in;
  logic [PRICE_W-1:0] rd_px;
  logic [LW-1:0]     last;
  logic              pushed, out_free;
  logic [LW-1:0]     bc, ac, lvl_a;
  logic              bv, av;

  assign bk       = cmd_q.book[BIW-1:0];
  assign bk_in    = cmd_i.book[BIW-1:0];
  assign waddr    = base_q + AW'(widx);
  assign raddr    = base_q + AW'(ridx);
  assign rd_px    = cmd_q.is_bid ? bid_rdata[PRICE_W-1:0] : ask_rdata[PRICE_W-1:0];
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign bc       = bid_cnt_q[bk];
  assign ac       = ask_cnt_q[bk];
  assign lvl_a    = (int'(cmd_q.level) < DEPTH) ? LW'(cmd_q.level) : '0;
  assign bv       = (cmd_q.kind != K_BAD) && (int'(cmd_q.level) < int'(bc));
  assign av       = (cmd_q.kind != K_BAD) && (int'(cmd_q.level) < int'(ac));

  always_comb begin
    out_data = '0;
    if (cmd_q.kind != K_BAD) begin
      out_data[15:0]  = bv ? bid_rdata[15:0]  : '0;
      out_data[31:16] = bv ? bid_rdata[31:16] : '0;
      out_data[47:32] = av ? ask_rdata[15:0]  : '0;
      out_data[63:48] = av ? ask_rdata[31:16] : '0;
      out_data[68:64] = CNT_O_W'(bc);
      out_data[73:69] = CNT_O_W'(ac);
      out_data[74]    = drop_q;
    end
  end

  plbu_ram #(.W(WORD_W), .D(MD)) u_bid_ram (
    .clk_i   (clk_i),
    .we_i    (we && cmd_q.is_bid),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (bid_rdata)
  );

  plbu_ram #(.W(WORD_W), .D(MD)) u_ask_ram (
    .clk_i   (clk_i),
    .we_i    (we && !cmd_q.is_bid),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (ask_rdata)
  );

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    base_d    = base_q;
    n_d       = n_q;
    pos_d     = pos_q;
    k_d       = k_q;
    del_d     = del_q;
    drop_d    = drop_q;
    cmd_pop_o = 1'b0;
    we        = 1'b0;
    widx      = pos_q;
    wdata     = {cmd_q.qty, cmd_q.price};
    ridx      = pos_q;
    cnt_we    = 1'b0;
    cnt_val   = n_q;
    dec_en    = 1'b0;
    dec_match = 1'b0;
    out_load  = 1'b0;
    pushed    = (n_q == LW'(DEPTH));
    last      = pushed ? LW'(DEPTH - 1) : n_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          base_d    = (cmd_i.kind == K_BAD) ? '0 : AW'(int'(bk_in) * DEPTH);
          n_d       = cmd_i.is_bid ? bid_cnt_q[bk_in] : ask_cnt_q[bk_in];
          pos_d     = '0;
          drop_d    = 1'b0;
          state_d   = (cmd_i.kind == K_DELTA) ? S_SCAN_RD : S_RES_RD;
        end
      end
      S_SCAN_RD: begin
        if (pos_q == n_q) begin
          dec_en = 1'b1;
        end else begin
          state_d = S_SCAN_CK;
        end
      end
      S_SCAN_CK: begin
        if (ranks_better(cmd_q.is_bid, rd_px, cmd_q.price)) begin
          pos_d   = pos_q + LW'(1);
          state_d = S_SCAN_RD;
        end else begin
          dec_en    = 1'b1;
          dec_match = (rd_px == cmd_q.price);
        end
      end
      S_SHIFT_RD: begin
        ridx    = del_q ? (k_q + LW'(1)) : (k_q - LW'(1));
        state_d = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        we    = 1'b1;
        widx  = k_q;
        wdata = cmd_q.is_bid ? bid_rdata : ask_rdata;
        if (del_q) begin
          if (int'(k_q) + 2 < int'(n_q)) begin
            k_d     = k_q + LW'(1);
            state_d = S_SHIFT_RD;
          end else begin
            state_d = S_RES_RD;
          end
        end else begin
          if (k_q - LW'(1) > pos_q) begin
            k_d     = k_q - LW'(1);
            state_d = S_SHIFT_RD;
          end else begin
            state_d = S_INS_WR;
          end
        end
      end
      S_INS_WR: begin
        we      = 1'b1;
        state_d = S_RES_RD;
      end
      S_RES_RD: begin
        ridx    = lvl_a;
        state_d = S_RES_CK;
      end
      S_RES_CK: begin
        ridx = lvl_a;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (dec_en) begin
      state_d = S_RES_RD;
      if (dec_match) begin
        if (cmd_q.qty != '0) begin
          we = 1'b1;
        end else begin
          cnt_we  = 1'b1;
          cnt_val = n_q - LW'(1);
          if (int'(pos_q) + 1 < int'(n_q)) begin
            del_d   = 1'b1;
            k_d     = pos_q;
            state_d = S_SHIFT_RD;
          end
        end
      end else if (cmd_q.qty != '0) begin
        if (int'(pos_q) >= DEPTH) begin
          drop_d = 1'b1;
        end else begin
          drop_d  = pushed;
          cnt_we  = !pushed;
          cnt_val = n_q + LW'(1);
          if (last > pos_q) begin
            del_d   = 1'b0;
            k_d     = last;
            state_d = S_SHIFT_RD;
          end else begin
            we = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    base_q <= base_d;
    n_q    <= n_d;
    pos_q  <= pos_d;
    k_q    <= k_d;
    del_q  <= del_d;
    drop_q <= drop_d;
    if (out_load) begin
      out_data_q <= out_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NBS; i++) begin
        bid_cnt_q[i] <= '0;
        ask_cnt_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cnt_we) begin
        if (cmd_q.is_bid) begin
          bid_cnt_q[bk] <= cnt_val;
        end else begin
          ask_cnt_q[bk] <= cnt_val;
        end
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

FILE: verif/price_level_book_update_tb.sv
// Self-checking testbench for price_level_book_update: directed and random
// depth deltas and level reads, predicted by a scoreboard holding its own books.
// Depends on plbu_pkg and the price_level_book_update RTL.
module price_level_book_update_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import plbu_pkg::*;

  localparam int NB = 16;
  localparam int DP = 16;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic                 dropped;
    logic [CNT_O_W-1:0]   ask_levels;
    logic [CNT_O_W-1:0]   bid_levels;
    logic [QTY_W-1:0]     ask_size;
    logic [PRICE_W-1:0]   ask_price;
    logic [QTY_W-1:0]     bid_size;
    logic [PRICE_W-1:0]   bid_price;
  } quote_t;

  class book_scoreboard;
    logic [PRICE_W-1:0] px[2][NB][DP];
    logic [QTY_W-1:0]   sz[2][NB][DP];
    int                 cnt[2][NB];
    quote_t             pending[$];
    int                 errors;

    function new();
      foreach (px[s, b, l]) begin
        px[s][b][l] = '0;
        sz[s][b][l] = '0;
      end
      foreach (cnt[s, b]) cnt[s][b] = 0;
      errors = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    // side 1 is bid (highest first), side 0 is ask (lowest first)
    function logic apply_delta(int s, int b, logic [PRICE_W-1:0] p, logic [QTY_W-1:0] q);
      int n;
      int pos;
      logic push;
      n = cnt[s][b];
      pos = 0;
      while (pos < n && (s ? px[s][b][pos] > p : px[s][b][pos] < p)) pos++;
      if (pos < n && px[s][b][pos] == p) begin
        if (q != 0) begin
          sz[s][b][pos] = q;
        end else begin
          for (int k = pos; k + 1 < n; k++) begin
            px[s][b][k] = px[s][b][k+1];
            sz[s][b][k] = sz[s][b][k+1];
          end
          px[s][b][n-1] = '0;
          sz[s][b][n-1] = '0;
          cnt[s][b] = n - 1;
        end
        return 1'b0;
      end
      if (q == 0) return 1'b0;
      if (pos >= DP) return 1'b1;
      push = (n == DP);
      for (int k = push ? DP - 1 : n; k > pos; k--) begin
        px[s][b][k] = px[s][b][k-1];
        sz[s][b][k] = sz[s][b][k-1];
      end
      px[s][b][pos] = p;
      sz[s][b][pos] = q;
      if (!push) cnt[s][b] = n + 1;
      return push;
    endfunction

    function void note_transfer(logic op, logic [IN_W-1:0] d);
      quote_t r;
      int b;
      int lv;
      r = '0;
      b = int'(d[3:0]);
      lv = int'(d[40:37]);
      if (op == OP_DELTA) begin
        if (d[20:5] != '0) r.dropped = apply_delta(d[4] ? 1 : 0, b, d[20:5], d[36:21]);
        lv = 0;
      end
      if (lv < cnt[1][b]) begin
        r.bid_price = px[1][b][lv];
        r.bid_size  = sz[1][b][lv];
      end
      if (lv < cnt[0][b]) begin
        r.ask_price = px[0][b][lv];
        r.ask_size  = sz[0][b][lv];
      end
      r.bid_levels = CNT_O_W'(cnt[1][b]);
      r.ask_levels = CNT_O_W'(cnt[0][b]);
      pending.push_back(r);
    endfunction

    task check_transfer(logic [OUT_W-1:0] d);
      quote_t got;
      quote_t exp_q;
      got = d[$bits(quote_t)-1:0];
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %h", d));
        return;
      end
      exp_q = pending.pop_front();
      if (got.bid_price != exp_q.bid_price)
        report($sformatf("bid_price %0d exp %0d", got.bid_price, exp_q.bid_price));
      if (got.bid_size != exp_q.bid_size)
        report($sformatf("bid_size %0d exp %0d", got.bid_size, exp_q.bid_size));
      if (got.ask_price != exp_q.ask_price)
        report($sformatf("ask_price %0d exp %0d", got.ask_price, exp_q.ask_price));
      if (got.ask_size != exp_q.ask_size)
        report($sformatf("ask_size %0d exp %0d", got.ask_size, exp_q.ask_size));
      if (got.bid_levels != exp_q.bid_levels)
        report($sformatf("bid_levels %0d exp %0d", got.bid_levels, exp_q.bid_levels));
      if (got.ask_levels != exp_q.ask_levels)
        report($sformatf("ask_levels %0d exp %0d", got.ask_levels, exp_q.ask_levels));
      if (got.dropped != exp_q.dropped)
        report($sformatf("dropped %0b exp %0b", got.dropped, exp_q.dropped));
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [IN_W-1:0]   s_axis_tdata_i = '0;
  logic              s_axis_tuser_i = 1'b0;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata_o;

  book_scoreboard    sb = new();
  int                sent = 0;
  bit                hold_req = 1'b0;
  bit                calm = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  price_level_book_update u_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o
  );

  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) sb.check_transfer(m_axis_tdata_o);
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int held;
    held = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && held < 300) begin
        m_axis_tready_i <= 1'b0;
        held++;
      end else begin
        m_axis_tready_i <= calm ? 1'b1 : ($urandom_range(99) >= 17);
      end
    end
  end

  task send_item(logic op, logic [3:0] book, logic bid, logic [15:0] p, logic [15:0] q,
                 logic [3:0] lv);
    logic [IN_W-1:0] d;
    d = '0;
    d[3:0] = book;
    d[4] = bid;
    d[20:5] = p;
    d[36:21] = q;
    d[40:37] = lv;
    while (!calm && $urandom_range(99) < 17) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= d;
    s_axis_tuser_i <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_transfer(op, d);
    sent++;
    @(negedge clk_i);
  endtask

  // stops offering and waits until every expected result has come
  task drain_input();
    s_axis_tvalid_i <= 1'b0;
    wait (sb.pending.size() == 0);
    @(negedge clk_i);
  endtask

  task send_delta(logic [3:0] book, logic bid, logic [15:0] p, logic [15:0] q);
    send_item(OP_DELTA, book, bid, p, q, 4'($urandom));
  endtask

  task send_read(logic [3:0] book, logic [3:0] lv);
    send_item(OP_READ, book, 1'($urandom), 16'($urandom), 16'($urandom), lv);
  endtask

  initial begin
    int b;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_read(4'd0, 4'd0);
    send_delta(4'd0, 1'b1, 16'd100, 16'd5);
    send_delta(4'd0, 1'b0, 16'd200, 16'd7);
    send_delta(4'd0, 1'b1, 16'd100, 16'd9);
    send_delta(4'd0, 1'b1, 16'd0, 16'd3);
    send_delta(4'd0, 1'b1, 16'd55, 16'd0);
    send_delta(4'd0, 1'b1, 16'hFFFF, 16'hFFFF);
    send_delta(4'd0, 1'b1, 16'hFFFF, 16'd0);
    send_read(4'd0, 4'd15);
    for (int i = 0; i < DP; i++) send_delta(4'd15, 1'b0, 16'd10 + 16'(2 * i), 16'(i + 1));
    send_delta(4'd15, 1'b0, 16'd500, 16'd1);
    send_delta(4'd15, 1'b0, 16'd1, 16'd2);
    send_read(4'd15, 4'd15);

    for (int i = 0; i < 700; i++) begin
      calm = (i >= 300 && i < 400);
      if (i == 200) hold_req = 1'b1;
      if (i == 500) drain_input();
      b = $urandom_range(3);
      case ($urandom_range(9))
        0, 1, 2, 3, 4: send_delta(4'(b), 1'($urandom), 16'($urandom_range(1, 40) * 50),
                                  ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom));
        5:       send_delta(4'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
        6:       send_delta(4'(b), 1'($urandom), 16'd0, 16'($urandom));
        default: send_read(($urandom_range(4) == 0) ? 4'($urandom) : 4'(b), 4'($urandom));
      endcase
    end
    calm = 1'b0;

    drain_input();
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
